// ----- design/chacha_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 package
// Shared types and constants for the ChaCha20 stream cipher block.
// ----------------------------------------------------------------------------
package chacha_pkg;

    typedef struct packed {
        logic [7:0] data_in;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } out_beat_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_NONCE0 = 3'd4;
    localparam logic [2:0] REG_NONCE1 = 3'd5;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    // Top-level control states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_XOR,
        ST_OUT
    } top_state_t;

    // Core sequencer states.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_LOAD,
        CS_RD,
        CS_QR,
        CS_WR,
        CS_FF_RD,
        CS_FF_WR
    } core_state_t;

    // Request and status between the top level and the block core.
    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } core_req_t;

    typedef struct packed {
        logic       done;
        logic       ks_we;
        logic [3:0] ks_addr;
        logic [31:0] ks_word;
    } core_rsp_t;

    // Quarter round on four words.
    function automatic logic [127:0] mix_words(input logic [127:0] abcd);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        a = abcd[127:96];
        b = abcd[95:64];
        c = abcd[63:32];
        d = abcd[31:0];
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        return {a, b, c, d};
    endfunction

endpackage

// ----- design/chacha_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 block core
// Runs the double rounds on a 16-word working memory, one quarter round per
// read-modify-write pass, then adds the input words back and emits words.
// ----------------------------------------------------------------------------
module chacha_core #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  chacha_pkg::core_req_t req,
    input  logic [63:0]           key_part0,
    input  logic [63:0]           key_part1,
    input  logic [63:0]           key_part2,
    input  logic [63:0]           key_part3,
    input  logic [63:0]           nonce_part0,
    input  logic [31:0]           nonce_part1,
    output chacha_pkg::core_rsp_t rsp
);

    localparam int RW = $clog2(DOUBLE_ROUNDS + 1);

    // Working words, four banks of four so a quarter round reads one per bank.
    logic [31:0] bank_a [4];
    logic [31:0] bank_b [4];
    logic [31:0] bank_c [4];
    logic [31:0] bank_d [4];

    chacha_pkg::core_state_t state_reg, state_next;
    logic [RW-1:0] round_reg, round_next;
    logic [2:0]    qr_reg, qr_next;
    logic [3:0]    word_reg, word_next;
    logic [31:0]   ctr_reg;

    logic [1:0]   ia, ib, ic, id;
    logic [31:0]  ra_reg, rb_reg, rc_reg, rd_reg;
    logic [127:0] qr_out;
    logic [31:0]  init_word;
    logic [31:0]  ff_word_reg;

    // Initial state words.
    always_comb
    begin
        case (word_reg)
            4'd0:  init_word = chacha_pkg::SIGMA0;
            4'd1:  init_word = chacha_pkg::SIGMA1;
            4'd2:  init_word = chacha_pkg::SIGMA2;
            4'd3:  init_word = chacha_pkg::SIGMA3;
            4'd4:  init_word = key_part0[31:0];
            4'd5:  init_word = key_part0[63:32];
            4'd6:  init_word = key_part1[31:0];
            4'd7:  init_word = key_part1[63:32];
            4'd8:  init_word = key_part2[31:0];
            4'd9:  init_word = key_part2[63:32];
            4'd10: init_word = key_part3[31:0];
            4'd11: init_word = key_part3[63:32];
            4'd12: init_word = ctr_reg;
            4'd13: init_word = nonce_part0[31:0];
            4'd14: init_word = nonce_part0[63:32];
            4'd15: init_word = nonce_part1;
            default: init_word = '0;
        endcase
    end

    // Column quarter rounds use one lane; diagonal ones shift b, c, d lanes.
    always_comb
    begin
        ia = qr_reg[1:0];
        if (qr_reg[2])
        begin
            ib = qr_reg[1:0] + 2'd1;
            ic = qr_reg[1:0] + 2'd2;
            id = qr_reg[1:0] + 2'd3;
        end
        else
        begin
            ib = qr_reg[1:0];
            ic = qr_reg[1:0];
            id = qr_reg[1:0];
        end
    end

    assign qr_out = chacha_pkg::mix_words({ra_reg, rb_reg, rc_reg, rd_reg});

    // Memory banks: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (state_reg == chacha_pkg::CS_LOAD)
        begin
            case (word_reg[3:2])
                2'd0: bank_a[word_reg[1:0]] <= init_word;
                2'd1: bank_b[word_reg[1:0]] <= init_word;
                2'd2: bank_c[word_reg[1:0]] <= init_word;
                default: bank_d[word_reg[1:0]] <= init_word;
            endcase
        end
        else if (state_reg == chacha_pkg::CS_WR)
        begin
            bank_a[ia] <= qr_out[127:96];
            bank_b[ib] <= qr_out[95:64];
            bank_c[ic] <= qr_out[63:32];
            bank_d[id] <= qr_out[31:0];
        end
        if (state_reg == chacha_pkg::CS_FF_RD)
        begin
            ra_reg <= bank_a[word_reg[1:0]];
            rb_reg <= bank_b[word_reg[1:0]];
            rc_reg <= bank_c[word_reg[1:0]];
            rd_reg <= bank_d[word_reg[1:0]];
        end
        else
        begin
            ra_reg <= bank_a[ia];
            rb_reg <= bank_b[ib];
            rc_reg <= bank_c[ic];
            rd_reg <= bank_d[id];
        end
    end

    // Feed-forward word picked from the read registers.
    always_ff @(posedge clk)
    begin
        case (word_reg[3:2])
            2'd0: ff_word_reg <= ra_reg + init_word;
            2'd1: ff_word_reg <= rb_reg + init_word;
            2'd2: ff_word_reg <= rc_reg + init_word;
            default: ff_word_reg <= rd_reg + init_word;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chacha_pkg::CS_IDLE;
            round_reg <= '0;
            qr_reg    <= '0;
            word_reg  <= '0;
            ctr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            qr_reg    <= qr_next;
            word_reg  <= word_next;
            if (req.start)
                ctr_reg <= req.counter;
        end
    end

    // Next-state logic. Feed-forward: FF_RD reads the word and registers the
    // sum over its phases, then FF_WR emits it.
    logic [1:0] ff_ph_reg, ff_ph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ff_ph_reg <= '0;
        else
            ff_ph_reg <= ff_ph_next;
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        qr_next    = qr_reg;
        word_next  = word_reg;
        ff_ph_next = ff_ph_reg;
        case (state_reg)
            chacha_pkg::CS_IDLE:
            begin
                if (req.start)
                begin
                    state_next = chacha_pkg::CS_LOAD;
                    word_next  = '0;
                end
            end
            chacha_pkg::CS_LOAD:
            begin
                word_next = word_reg + 4'd1;
                if (word_reg == 4'd15)
                begin
                    state_next = chacha_pkg::CS_RD;
                    round_next = '0;
                    qr_next    = '0;
                end
            end
            chacha_pkg::CS_RD:
                state_next = chacha_pkg::CS_QR;
            chacha_pkg::CS_QR:
                state_next = chacha_pkg::CS_WR;
            chacha_pkg::CS_WR:
            begin
                qr_next = qr_reg + 3'd1;
                if (qr_reg == 3'd7)
                begin
                    round_next = round_reg + RW'(1);
                    if (round_reg == RW'(DOUBLE_ROUNDS - 1))
                    begin
                        state_next = chacha_pkg::CS_FF_RD;
                        word_next  = '0;
                        ff_ph_next = '0;
                    end
                    else
                        state_next = chacha_pkg::CS_RD;
                end
                else
                    state_next = chacha_pkg::CS_RD;
            end
            chacha_pkg::CS_FF_RD:
            begin
                ff_ph_next = ff_ph_reg + 2'd1;
                if (ff_ph_reg == 2'd2)
                begin
                    state_next = chacha_pkg::CS_FF_WR;
                    ff_ph_next = '0;
                end
            end
            chacha_pkg::CS_FF_WR:
            begin
                word_next = word_reg + 4'd1;
                if (word_reg == 4'd15)
                    state_next = chacha_pkg::CS_IDLE;
                else
                    state_next = chacha_pkg::CS_FF_RD;
            end
            default:
                state_next = chacha_pkg::CS_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        rsp.ks_we   = (state_reg == chacha_pkg::CS_FF_WR);
        rsp.ks_addr = word_reg;
        rsp.ks_word = ff_word_reg;
        rsp.done    = (state_reg == chacha_pkg::CS_FF_WR) && (word_reg == 4'd15);
    end

endmodule

// ----- design/chacha20_stream_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ChaCha20 stream cipher
// Each input beat carries one byte, XORed with the next keystream byte.
// At each 64-byte boundary, and after a last byte, a keystream block is
// computed in a working-word memory, one quarter round per read-modify-write
// pass, through load, round and feed-forward phases, before the first byte
// of the block. Other bytes go through keystream memory read, XOR and output
// in turn; no new byte is accepted until the output has been taken.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  chacha_pkg::in_beat_t   in_beat,
    output logic                   out_valid,
    input  logic                   out_stall,
    output chacha_pkg::out_beat_t  out_beat
);

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonce0_reg;
    logic [31:0] nonce1_reg;

    chacha_pkg::top_state_t state_reg, state_next;
    logic [31:0] ctr_reg;
    logic [5:0]  pos_reg;
    chacha_pkg::in_beat_t hold_reg;
    chacha_pkg::out_beat_t out_reg;

    chacha_pkg::core_req_t req;
    chacha_pkg::core_rsp_t rsp;

    // Keystream memory: 16 words of 32 bits.
    logic [31:0] ks_mem [16];
    logic [31:0] ks_rd_reg;
    logic [7:0]  ks_byte;

    logic accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg   <= '0;
            key1_reg   <= '0;
            key2_reg   <= '0;
            key3_reg   <= '0;
            nonce0_reg <= '0;
            nonce1_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                chacha_pkg::REG_KEY0:   key0_reg   <= cfg_data;
                chacha_pkg::REG_KEY1:   key1_reg   <= cfg_data;
                chacha_pkg::REG_KEY2:   key2_reg   <= cfg_data;
                chacha_pkg::REG_KEY3:   key3_reg   <= cfg_data;
                chacha_pkg::REG_NONCE0: nonce0_reg <= cfg_data;
                chacha_pkg::REG_NONCE1: nonce1_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    chacha_core #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .key_part0   (key0_reg),
        .key_part1   (key1_reg),
        .key_part2   (key2_reg),
        .key_part3   (key3_reg),
        .nonce_part0 (nonce0_reg),
        .nonce_part1 (nonce1_reg),
        .rsp         (rsp)
    );

    assign accept = in_valid && !in_stall;

    // Keystream memory write and registered read.
    always_ff @(posedge clk)
    begin
        if (rsp.ks_we)
            ks_mem[rsp.ks_addr] <= rsp.ks_word;
        ks_rd_reg <= ks_mem[pos_reg[5:2]];
        if (accept)
            hold_reg <= in_beat;
    end

    always_comb
    begin
        case (pos_reg[1:0])
            2'd0: ks_byte = ks_rd_reg[7:0];
            2'd1: ks_byte = ks_rd_reg[15:8];
            2'd2: ks_byte = ks_rd_reg[23:16];
            default: ks_byte = ks_rd_reg[31:24];
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chacha_pkg::ST_IDLE;
            ctr_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == chacha_pkg::ST_XOR)
            begin
                if (hold_reg.last_byte)
                begin
                    ctr_reg <= '0;
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (pos_reg == 6'd0)
                        ctr_reg <= ctr_reg + 32'd1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (state_reg == chacha_pkg::ST_XOR)
        begin
            out_reg.data_out <= hold_reg.data_in ^ ks_byte;
            out_reg.last_out <= hold_reg.last_byte;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            chacha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (pos_reg == 6'd0)
                        state_next = chacha_pkg::ST_GEN;
                    else
                        state_next = chacha_pkg::ST_XOR;
                end
            end
            chacha_pkg::ST_GEN:
            begin
                if (rsp.done)
                    state_next = chacha_pkg::ST_XOR;
            end
            chacha_pkg::ST_XOR:
                state_next = chacha_pkg::ST_OUT;
            chacha_pkg::ST_OUT:
            begin
                if (!out_stall)
                    state_next = chacha_pkg::ST_IDLE;
            end
            default:
                state_next = chacha_pkg::ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall    = (state_reg != chacha_pkg::ST_IDLE);
        out_valid   = (state_reg == chacha_pkg::ST_OUT);
        out_beat    = out_reg;
        req.start   = (state_reg == chacha_pkg::ST_IDLE) && accept && (pos_reg == 6'd0);
        req.counter = ctr_reg;
    end

endmodule
